// ----- rtl/mrg3_pkg.sv -----
// shared types and constants of the third-order recursive generator
`default_nettype none

package mrg3_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned ProdW  = WordW + CoefW;
  localparam int unsigned AccW   = ProdW + 2;
  localparam int unsigned HiW    = AccW - WordW;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  // modulus 2^32 - 5, so 2^32 folds back as 5
  localparam logic [WordW-1:0] Modulus  = 32'hFFFF_FFFB;
  localparam logic [WordW:0]   FoldBack = 33'd5;

  localparam logic [CoefW-1:0] CoefFirstRst  = 16'd1176;
  localparam logic [CoefW-1:0] CoefSecondRst = 16'd1476;
  localparam logic [CoefW-1:0] CoefThirdRst  = 16'd1776;
  localparam logic [WordW-1:0] SeedRst       = 32'd10;
  localparam logic [WordW-1:0] HistoryRst    = 32'd10;

  typedef enum logic [1:0] {
    REG_COEF_FIRST  = 2'd0,
    REG_COEF_SECOND = 2'd1,
    REG_COEF_THIRD  = 2'd2,
    REG_SEED_VALUE  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CoefW-1:0] first;
    logic [CoefW-1:0] second;
    logic [CoefW-1:0] third;
  } coef_set_t;

  typedef struct packed {
    logic [WordW-1:0] newest;
    logic [WordW-1:0] middle;
    logic [WordW-1:0] oldest;
  } history_t;

endpackage

`default_nettype wire

// ----- rtl/mrg3_step.sv -----
// weighted history sum and reduction modulo 2^32-5
`default_nettype none

module mrg3_step (
  input  mrg3_pkg::coef_set_t         coef_i,
  input  mrg3_pkg::history_t          hist_i,
  output logic [mrg3_pkg::WordW-1:0]  sample_o
);
  import mrg3_pkg::*;

  logic [ProdW-1:0] prod_new, prod_mid, prod_old;
  logic [AccW-1:0]  acc;
  logic [HiW-1:0]   acc_hi;
  logic [WordW:0]   fold1, fold2;

  assign prod_new = ProdW'(coef_i.first)  * ProdW'(hist_i.newest);
  assign prod_mid = ProdW'(coef_i.second) * ProdW'(hist_i.middle);
  assign prod_old = ProdW'(coef_i.third)  * ProdW'(hist_i.oldest);

  assign acc = AccW'(prod_new) + AccW'(prod_mid) + AccW'(prod_old);

  // first fold: high part times five (shift and add)
  assign acc_hi = acc[AccW-1:WordW];
  assign fold1  = {1'b0, acc[WordW-1:0]}
                + (WordW+1)'({acc_hi, 2'b00}) + (WordW+1)'(acc_hi);

  // second fold: the carry is at most one
  assign fold2 = {1'b0, fold1[WordW-1:0]} + (fold1[WordW] ? FoldBack : '0);

  // fold2 stays below twice the modulus: one conditional subtract
  always_comb begin
    if (fold2 >= {1'b0, Modulus}) begin
      sample_o = WordW'(fold2 - {1'b0, Modulus});
    end else begin
      sample_o = fold2[WordW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/third_order_mrg_generator_core.sv -----
// top level of the third-order multiple recursive generator
`default_nettype none

// channel   direction  handshake                  payload
// input     in         in_valid_i / in_stall_o    reseed_i   (1 bit)
// output    out        out_valid_o / out_stall_i  sample_o   (32 bit)
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// one transaction per clock cycle while in_stall_o is low: the recurrence
// from the history registers through the three products and the modulo
// fold back into the history is combinational, and that loop sets the rate
// a result is registered in out_q, or in skid_q while out_q is held
// reset loads the coefficient, seed and history reset values and empties the
// two-entry output buffer
// in_stall_o rises only when both output entries hold untaken results

module third_order_mrg_generator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            reseed_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mrg3_pkg::WordW-1:0]      sample_o,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mrg3_pkg::ApbAddrW-1:0]   paddr,
  input  logic [mrg3_pkg::ApbDataW-1:0]   pwdata,
  output logic [mrg3_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);
  import mrg3_pkg::*;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  coef_set_t        coef_q;
  logic [WordW-1:0] seed_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.first  <= CoefFirstRst;
      coef_q.second <= CoefSecondRst;
      coef_q.third  <= CoefThirdRst;
      seed_q        <= SeedRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COEF_FIRST:  coef_q.first  <= pwdata[CoefW-1:0];
        REG_COEF_SECOND: coef_q.second <= pwdata[CoefW-1:0];
        REG_COEF_THIRD:  coef_q.third  <= pwdata[CoefW-1:0];
        REG_SEED_VALUE:  seed_q        <= pwdata[WordW-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero-extended
  always_comb begin
    unique case (cfg_idx)
      REG_COEF_FIRST:  prdata = ApbDataW'(coef_q.first);
      REG_COEF_SECOND: prdata = ApbDataW'(coef_q.second);
      REG_COEF_THIRD:  prdata = ApbDataW'(coef_q.third);
      REG_SEED_VALUE:  prdata = ApbDataW'(seed_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // history and next value
  // ---------------------------------------------------------------------
  history_t         hist_q, hist_d, hist_used;
  logic [WordW-1:0] next_sample;
  logic             in_accept;

  // a reseed replaces all three words before this step
  always_comb begin
    if (reseed_i) begin
      hist_used.newest = seed_q;
      hist_used.middle = seed_q;
      hist_used.oldest = seed_q;
    end else begin
      hist_used = hist_q;
    end
  end

  mrg3_step u_step (
    .coef_i   (coef_q),
    .hist_i   (hist_used),
    .sample_o (next_sample)
  );

  // history shifts by one word per transaction
  always_comb begin
    hist_d = hist_q;
    if (in_accept) begin
      hist_d.oldest = hist_used.middle;
      hist_d.middle = hist_used.newest;
      hist_d.newest = next_sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q.newest <= HistoryRst;
      hist_q.middle <= HistoryRst;
      hist_q.oldest <= HistoryRst;
    end else begin
      hist_q <= hist_d;
    end
  end

  // ---------------------------------------------------------------------
  // two-entry output buffer: main register plus skid register
  // ---------------------------------------------------------------------
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  logic [WordW-1:0] out_q, out_d;
  logic [WordW-1:0] skid_q, skid_d;
  logic             out_pop, out_free;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i & ~skid_valid_q;
  assign out_pop    = out_valid_q & ~out_stall_i;
  assign out_free   = ~out_valid_q | out_pop;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // skid entry moves up, no new transaction this cycle
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = next_sample;
        out_valid_d = in_accept;
      end
    end else if (in_accept) begin
      skid_d       = next_sample;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_q;

endmodule

`default_nettype wire
